/* hdl/dcp_pkg.sv */
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants of the distance constraint projector.
// ----------------------------------------------------------------------------
package dcp_pkg;

	localparam int PARTICLE_COUNT_DEF = 1024;
	localparam int ID_W               = 10;
	localparam int COORD_W            = 32;
	localparam int POS_W              = 3 * COORD_W;
	localparam int CFG_IDX_W          = 2;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_PROJECT = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_STRETCH = 2'd0,
		CFG_ALPHA_BEND    = 2'd1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_LDB,
		S_CHK,
		S_SQ,
		S_SQACC,
		S_SQRT,
		S_LEN,
		S_DIVR0,
		S_DIVR1,
		S_MM0,
		S_MM1,
		S_MM2,
		S_DIVU,
		S_MVA,
		S_MVB,
		S_APPLY,
		S_WRA,
		S_WRB,
		S_DONE
	} state_t;

endpackage

/* hdl/distance_constraint_projector.sv */
// ----------------------------------------------------------------------------
// distance_constraint_projector
// Particle store with an iterative compliant distance constraint projector.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. operation
// selects a particle write, a particle read or the projection of one distance
// constraint between id_a and id_b. Each request gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
// A projection ends early and reports skipped when both inverse masses are
// zero or the distance is zero. One request is worked on at a time; the next
// is taken only after done. Projection time is set by the bit-serial square
// root (34 steps) and the shared restoring divider (31 steps each for two
// mass ratios and three unit vector components), all around one shared
// multiplier.
// Positions and inverse masses sit in two RAMs with registered reads; a
// projection reads both particles, works on copies and writes both back.
// Registers alpha_stretch and alpha_bend are written over the cfg channel,
// which is always ready; write them only while the block is idle.
// Reset clears the sequencer and both alpha registers; RAM contents are
// undefined until written.
// ----------------------------------------------------------------------------
module distance_constraint_projector #(
	parameter int PARTICLE_COUNT = dcp_pkg::PARTICLE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic [1:0]                     operation,
	input  logic [dcp_pkg::ID_W-1:0]       id_a,
	input  logic [dcp_pkg::ID_W-1:0]       id_b,
	input  logic                           constraint_kind,
	input  logic [31:0]                    rest_length,
	input  logic signed [31:0]             write_x,
	input  logic signed [31:0]             write_y,
	input  logic signed [31:0]             write_z,
	input  logic [31:0]                    write_inv_mass,
	output logic signed [31:0]             read_x,
	output logic signed [31:0]             read_y,
	output logic signed [31:0]             read_z,
	output logic [31:0]                    read_inv_mass,
	output logic                           skipped,
	output logic                           saturated,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	import dcp_pkg::*;

	localparam int AW = $clog2(PARTICLE_COUNT);

	state_t state_q, state_d;
	op_t    op_q;
	logic [AW-1:0] ida_q, idb_q;
	logic          kind_q;
	logic [31:0]   rest_q;
	logic [31:0]   alpha_stretch_q, alpha_bend_q;

	logic signed [31:0] pa_q [3];
	logic signed [31:0] pb_q [3];
	logic [31:0] wa_q, wb_q;
	logic [32:0] dabs_q [3];
	logic [2:0]  dneg_q;

	logic [67:0] sum_q, rad_q;
	logic [35:0] sq_rem_q;
	logic [33:0] root_q;
	logic [33:0] ac_q;
	logic        cneg_q;

	logic [35:0] div_rem_q;
	logic [30:0] div_quo_q;
	logic [34:0] div_den_q;
	logic        div_lsb_q;
	logic [30:0] r0_q, r1_q, u_q;
	logic [33:0] m0_q, m1_q, ma_q;

	logic [5:0] cnt_q;
	logic [1:0] k_q;

	logic [33:0] mul_a, mul_b;
	logic [67:0] prod_q;

	logic signed [31:0] read_x_q, read_y_q, read_z_q;
	logic [31:0] read_inv_mass_q;
	logic        skip_q, sat_q;

	logic          accept;
	logic [AW-1:0] ida_in, idb_in;
	logic          pos_we, mass_we;
	logic [AW-1:0] waddr, raddr;
	logic [POS_W-1:0] pos_wdata, pos_rdata;
	logic [31:0]   mass_rdata;

	// divider and square root step
	logic        div_bit;
	logic [36:0] div_t;
	logic        div_ge;
	logic [35:0] div_rem_n;
	logic [30:0] div_quo_n;
	logic [37:0] sq_t, sq_trial;
	logic        sq_ge;
	logic [35:0] sq_rem_n;

	logic signed [34:0] c_s;
	logic [33:0] ac_n;
	logic [34:0] den_w;
	logic [31:0] alpha_sel;

	logic        sg;
	logic [35:0] ma_ext, mb_ext, add_a, add_b, sum_a, sum_b;
	logic [32:0] cl_a, cl_b;
	logic signed [32:0] d_n [3];

	function automatic logic [ID_W-1:0] wrap_id(input logic [ID_W-1:0] v);
		logic [31:0] lim;
		logic [ID_W-1:0] r;
		r = v;
		for (int j = ID_W - 1; j >= 0; j--) begin
			lim = 32'(PARTICLE_COUNT) << j;
			if (lim < (32'd1 << ID_W) && 32'(r) >= lim) begin
				r = r - ID_W'(lim);
			end
		end
		return r;
	endfunction

	// {clamped flag, value}
	function automatic logic [32:0] clamp32(input logic [35:0] v);
		logic [32:0] r;
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
			r = {1'b0, v[31:0]};
		end else if (v[35]) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b1, 32'h7FFF_FFFF};
		end
		return r;
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign ida_in    = AW'(wrap_id(id_a));
	assign idb_in    = AW'(wrap_id(id_b));

	assign read_x        = read_x_q;
	assign read_y        = read_y_q;
	assign read_z        = read_z_q;
	assign read_inv_mass = read_inv_mass_q;
	assign skipped       = skip_q;
	assign saturated     = sat_q;

	dcp_ram #(.WIDTH(POS_W), .DEPTH(PARTICLE_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (waddr),
		.wdata (pos_wdata),
		.raddr (raddr),
		.rdata (pos_rdata)
	);

	dcp_ram #(.WIDTH(32), .DEPTH(PARTICLE_COUNT)) u_mass_ram (
		.clk   (clk),
		.we    (mass_we),
		.waddr (waddr),
		.wdata (write_inv_mass),
		.raddr (raddr),
		.rdata (mass_rdata)
	);

	// ---- arithmetic steps ----
	always_comb begin
		div_bit   = (cnt_q == 6'd0) ? div_lsb_q : 1'b0;
		div_t     = {div_rem_q, div_bit};
		div_ge    = (div_t >= {2'b00, div_den_q});
		div_rem_n = div_ge ? 36'(div_t - {2'b00, div_den_q}) : div_t[35:0];
		div_quo_n = {div_quo_q[29:0], div_ge};

		sq_t     = {sq_rem_q, rad_q[67:66]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_t >= sq_trial);
		sq_rem_n = sq_ge ? 36'(sq_t - sq_trial) : sq_t[35:0];

		alpha_sel = kind_q ? alpha_bend_q : alpha_stretch_q;
		c_s   = $signed({1'b0, root_q}) - $signed({3'b000, rest_q});
		ac_n  = c_s[34] ? 34'(35'd0 - c_s) : c_s[33:0];
		den_w = 35'(wa_q) + 35'(wb_q) + 35'(alpha_sel);

		sg     = cneg_q ^ dneg_q[k_q];
		ma_ext = {2'b00, ma_q};
		mb_ext = {2'b00, prod_q[63:30]};
		add_a  = sg ? ma_ext : 36'd0 - ma_ext;
		add_b  = sg ? 36'd0 - mb_ext : mb_ext;
		sum_a  = {{4{pa_q[k_q][31]}}, pa_q[k_q]} + add_a;
		sum_b  = {{4{pb_q[k_q][31]}}, pb_q[k_q]} + add_b;
		cl_a   = clamp32(sum_a);
		cl_b   = clamp32(sum_b);

		for (int i = 0; i < 3; i++) begin
			d_n[i] = $signed({pa_q[i][31], pa_q[i]}) - $signed({pb_q[i][31], pb_q[i]});
		end
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_WRITE) begin
						state_d = S_DONE;
					end else if (operation == OP_PROJECT || operation == OP_READ) begin
						state_d = S_RDA;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = (op_q == OP_READ) ? S_DONE : S_LDB;
			S_LDB:   state_d = S_CHK;
			S_CHK:   state_d = (wa_q == 32'd0 && wb_q == 32'd0) ? S_DONE : S_SQ;
			S_SQ:    state_d = S_SQACC;
			S_SQACC: state_d = (k_q == 2'd2) ? S_SQRT : S_SQ;
			S_SQRT:  state_d = (cnt_q == 6'd33) ? S_LEN : S_SQRT;
			S_LEN:   state_d = (root_q == 34'd0) ? S_DONE : S_DIVR0;
			S_DIVR0: state_d = (cnt_q == 6'd30) ? S_DIVR1 : S_DIVR0;
			S_DIVR1: state_d = (cnt_q == 6'd30) ? S_MM0 : S_DIVR1;
			S_MM0:   state_d = S_MM1;
			S_MM1:   state_d = S_MM2;
			S_MM2:   state_d = S_DIVU;
			S_DIVU:  state_d = (cnt_q == 6'd30) ? S_MVA : S_DIVU;
			S_MVA:   state_d = S_MVB;
			S_MVB:   state_d = S_APPLY;
			S_APPLY: state_d = (k_q == 2'd2) ? S_WRA : S_DIVU;
			S_WRA:   state_d = S_WRB;
			S_WRB:   state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---- outputs: memory control, multiplier operands, strobe ----
	always_comb begin
		pos_we    = 1'b0;
		mass_we   = 1'b0;
		waddr     = ida_in;
		pos_wdata = {write_x, write_y, write_z};
		raddr     = ida_q;
		mul_a     = 34'd0;
		mul_b     = 34'd0;
		done      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_WRITE) begin
					pos_we  = 1'b1;
					mass_we = 1'b1;
				end
			end
			S_RDB: raddr = idb_q;
			S_SQ: begin
				mul_a = {1'b0, dabs_q[k_q]};
				mul_b = {1'b0, dabs_q[k_q]};
			end
			S_MM0: begin
				mul_a = ac_q;
				mul_b = {3'b000, r0_q};
			end
			S_MM1: begin
				mul_a = ac_q;
				mul_b = {3'b000, r1_q};
			end
			S_MVA: begin
				mul_a = m0_q;
				mul_b = {3'b000, u_q};
			end
			S_MVB: begin
				mul_a = m1_q;
				mul_b = {3'b000, u_q};
			end
			S_WRA: begin
				pos_we    = 1'b1;
				waddr     = ida_q;
				pos_wdata = {pa_q[0], pa_q[1], pa_q[2]};
			end
			S_WRB: begin
				pos_we    = 1'b1;
				waddr     = idb_q;
				pos_wdata = {pb_q[0], pb_q[1], pb_q[2]};
			end
			S_DONE: done = 1'b1;
			default: ;
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			k_q             <= '0;
			alpha_stretch_q <= '0;
			alpha_bend_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ALPHA_STRETCH: alpha_stretch_q <= cfg_data;
					CFG_ALPHA_BEND:    alpha_bend_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					k_q   <= '0;
				end
				S_SQACC: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				S_SQRT:  cnt_q <= (cnt_q == 6'd33) ? 6'd0 : cnt_q + 6'd1;
				S_DIVR0, S_DIVR1, S_DIVU: begin
					cnt_q <= (cnt_q == 6'd30) ? 6'd0 : cnt_q + 6'd1;
				end
				S_APPLY: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				default: ;
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q            <= op_t'(operation);
					ida_q           <= ida_in;
					idb_q           <= idb_in;
					kind_q          <= constraint_kind;
					rest_q          <= rest_length;
					read_x_q        <= '0;
					read_y_q        <= '0;
					read_z_q        <= '0;
					read_inv_mass_q <= '0;
					skip_q          <= 1'b0;
					sat_q           <= 1'b0;
				end
			end
			S_RDB: begin
				pa_q[0] <= pos_rdata[95:64];
				pa_q[1] <= pos_rdata[63:32];
				pa_q[2] <= pos_rdata[31:0];
				wa_q    <= mass_rdata;
				if (op_q == OP_READ) begin
					read_x_q        <= pos_rdata[95:64];
					read_y_q        <= pos_rdata[63:32];
					read_z_q        <= pos_rdata[31:0];
					read_inv_mass_q <= mass_rdata;
				end
			end
			S_LDB: begin
				pb_q[0] <= pos_rdata[95:64];
				pb_q[1] <= pos_rdata[63:32];
				pb_q[2] <= pos_rdata[31:0];
				wb_q    <= mass_rdata;
			end
			S_CHK: begin
				if (wa_q == 32'd0 && wb_q == 32'd0) begin
					skip_q <= 1'b1;
				end
				for (int i = 0; i < 3; i++) begin
					dneg_q[i] <= d_n[i][32];
					dabs_q[i] <= d_n[i][32] ? 33'(33'd0 - d_n[i]) : d_n[i];
				end
				sum_q <= '0;
			end
			S_SQACC: begin
				sum_q <= sum_q + prod_q;
				if (k_q == 2'd2) begin
					rad_q    <= sum_q + prod_q;
					sq_rem_q <= '0;
					root_q   <= '0;
				end
			end
			S_SQRT: begin
				sq_rem_q <= sq_rem_n;
				root_q   <= {root_q[32:0], sq_ge};
				rad_q    <= {rad_q[65:0], 2'b00};
			end
			S_LEN: begin
				if (root_q == 34'd0) begin
					skip_q <= 1'b1;
				end
				ac_q      <= ac_n;
				cneg_q    <= c_s[34];
				div_den_q <= den_w;
				div_rem_q <= 36'(wa_q >> 1);
				div_lsb_q <= wa_q[0];
				div_quo_q <= '0;
			end
			S_DIVR0: begin
				if (cnt_q == 6'd30) begin
					r0_q      <= div_quo_n;
					div_rem_q <= 36'(wb_q >> 1);
					div_lsb_q <= wb_q[0];
					div_quo_q <= '0;
				end else begin
					div_rem_q <= div_rem_n;
					div_quo_q <= div_quo_n;
				end
			end
			S_DIVR1: begin
				div_rem_q <= div_rem_n;
				div_quo_q <= div_quo_n;
				if (cnt_q == 6'd30) begin
					r1_q <= div_quo_n;
				end
			end
			S_MM1: m0_q <= prod_q[63:30];
			S_MM2: begin
				m1_q      <= prod_q[63:30];
				div_den_q <= {1'b0, root_q};
				div_rem_q <= 36'(dabs_q[0] >> 1);
				div_lsb_q <= dabs_q[0][0];
				div_quo_q <= '0;
			end
			S_DIVU: begin
				div_rem_q <= div_rem_n;
				div_quo_q <= div_quo_n;
				if (cnt_q == 6'd30) begin
					u_q <= div_quo_n;
				end
			end
			S_MVB: ma_q <= prod_q[63:30];
			S_APPLY: begin
				pa_q[k_q] <= cl_a[31:0];
				pb_q[k_q] <= cl_b[31:0];
				if (cl_a[32] || cl_b[32]) begin
					sat_q <= 1'b1;
				end
				// prime the divider for the next axis
				if (k_q != 2'd2) begin
					div_rem_q <= 36'(dabs_q[k_q + 2'd1] >> 1);
					div_lsb_q <= dabs_q[k_q + 2'd1][0];
					div_quo_q <= '0;
				end
			end
			default: ;
		endcase
	end

	// ---- assertions ----
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted but block not busy");

	a_flags_project: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != OP_PROJECT) |-> (!skipped && !saturated))
		else $error("projection flags set on a non-projection result");

	a_skip_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(skipped && saturated))
		else $error("skipped projection reports saturation");

	a_wrb_after_wra: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB) |-> $past(state_q == S_WRA))
		else $error("second write-back without the first");

endmodule

/* hdl/dcp_ram.sv */
// ----------------------------------------------------------------------------
// dcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
